// ----- src/range_image_to_point_cloud_unit_defines.svh -----
// assertion macros shared by the range image to point cloud rtl
`ifndef RANGE_IMAGE_TO_POINT_CLOUD_UNIT_DEFINES_SVH
`define RANGE_IMAGE_TO_POINT_CLOUD_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rip_pkg.sv -----
// package with widths, constants, config struct and helpers
`timescale 1ns / 1ps
package rip_pkg;

	localparam int ColW = 12;
	localparam int RowW = 10;
	localparam int RangeW = 20;
	localparam int IntenW = 16;
	localparam int CoordW = 21;
	localparam int AngW = 16;
	localparam int StepW = 15;
	localparam int SinW = 18;
	localparam int RsW = 38;
	localparam int ProdW = 56;
	localparam int WideW = 58;
	localparam int AddrW = 5;
	localparam int DataW = 32;

	localparam int MaxColumns = 4096;
	localparam int MaxRows = 1024;

	localparam int SinA = 102944;
	localparam int SinB = 42047;
	localparam int SinC = 4640;
	localparam int CoordLimit = 1048575;
	localparam logic [AngW-1:0] QuarterTurn = 16'h4000;
	localparam logic [RangeW-1:0] RangeMaxReset = 20'hFFFFF;

	localparam logic [2:0] RegHAngleMin = 3'd0;
	localparam logic [2:0] RegHAngleStep = 3'd1;
	localparam logic [2:0] RegVAngleMin = 3'd2;
	localparam logic [2:0] RegVAngleStep = 3'd3;
	localparam logic [2:0] RegCenterAngle = 3'd4;
	localparam logic [2:0] RegRangeMin = 3'd5;
	localparam logic [2:0] RegRangeMax = 3'd6;
	localparam logic [2:0] RegHorizontalMode = 3'd7;

	typedef struct packed {
		logic [AngW-1:0] h_angle_min;
		logic [StepW-1:0] h_angle_step;
		logic [AngW-1:0] v_angle_min;
		logic [StepW-1:0] v_angle_step;
		logic [AngW-1:0] center_angle;
		logic [RangeW-1:0] range_lo;
		logic [RangeW-1:0] range_hi;
		logic horizontal_mode;
	} rip_cfg_t;

	localparam rip_cfg_t CfgReset = '{16'h0, 15'h0, 16'h0, 15'h0, 16'h0, 20'h0,
		RangeMaxReset, 1'b0};

	// round half up, then arithmetic shift by n
	function automatic logic signed [WideW-1:0] rnd_sh(input logic signed [WideW-1:0] v,
			input int unsigned n);
		logic signed [WideW-1:0] half;
		half = 58'sd1 <<< (n - 1);
		rnd_sh = (v + half) >>> n;
	endfunction

	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [WideW-1:0] v);
		logic signed [WideW-1:0] lim;
		lim = WideW'(CoordLimit);
		if (v > lim) begin
			sat_coord = CoordW'(CoordLimit);
		end else if (v < -lim) begin
			sat_coord = -CoordW'(CoordLimit);
		end else begin
			sat_coord = v[CoordW-1:0];
		end
	endfunction

endpackage

// ----- src/rip_if.sv -----
// stream interfaces for lidar samples and points
`timescale 1ns / 1ps
interface rip_in_if;
	logic valid;
	logic ready;
	logic [rip_pkg::ColW-1:0] column;
	logic [rip_pkg::RowW-1:0] row;
	logic [rip_pkg::RangeW-1:0] sample_range;
	logic [rip_pkg::IntenW-1:0] sample_intensity;
	modport source(output valid, column, row, sample_range, sample_intensity, input ready);
	modport sink(input valid, column, row, sample_range, sample_intensity, output ready);
endinterface

interface rip_out_if;
	logic valid;
	logic ready;
	logic signed [rip_pkg::CoordW-1:0] point_x;
	logic signed [rip_pkg::CoordW-1:0] point_y;
	logic signed [rip_pkg::CoordW-1:0] point_z;
	logic [rip_pkg::IntenW-1:0] point_intensity;
	modport source(output valid, point_x, point_y, point_z, point_intensity, input ready);
	modport sink(input valid, point_x, point_y, point_z, point_intensity, output ready);
endinterface

// ----- src/rip_regs.sv -----
// apb configuration registers
`timescale 1ns / 1ps
module rip_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rip_pkg::AddrW-1:0] paddr,
	input logic [rip_pkg::DataW-1:0] pwdata,
	output logic [rip_pkg::DataW-1:0] prdata,
	output logic pready,
	output rip_pkg::rip_cfg_t cfg
);
	rip_pkg::rip_cfg_t cfg_q;
	logic wr;

	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rip_pkg::CfgReset;
		end else if (wr) begin
			unique case (paddr[4:2])
				rip_pkg::RegHAngleMin: cfg_q.h_angle_min <= pwdata[15:0];
				rip_pkg::RegHAngleStep: cfg_q.h_angle_step <= pwdata[14:0];
				rip_pkg::RegVAngleMin: cfg_q.v_angle_min <= pwdata[15:0];
				rip_pkg::RegVAngleStep: cfg_q.v_angle_step <= pwdata[14:0];
				rip_pkg::RegCenterAngle: cfg_q.center_angle <= pwdata[15:0];
				rip_pkg::RegRangeMin: cfg_q.range_lo <= pwdata[19:0];
				rip_pkg::RegRangeMax: cfg_q.range_hi <= pwdata[19:0];
				rip_pkg::RegHorizontalMode: cfg_q.horizontal_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			rip_pkg::RegHAngleMin: prdata = 32'(cfg_q.h_angle_min);
			rip_pkg::RegHAngleStep: prdata = 32'(cfg_q.h_angle_step);
			rip_pkg::RegVAngleMin: prdata = 32'(cfg_q.v_angle_min);
			rip_pkg::RegVAngleStep: prdata = 32'(cfg_q.v_angle_step);
			rip_pkg::RegCenterAngle: prdata = 32'(cfg_q.center_angle);
			rip_pkg::RegRangeMin: prdata = 32'(cfg_q.range_lo);
			rip_pkg::RegRangeMax: prdata = 32'(cfg_q.range_hi);
			rip_pkg::RegHorizontalMode: prdata = 32'(cfg_q.horizontal_mode);
			default: prdata = '0;
		endcase
	end
endmodule

// ----- src/rip_sine.sv -----
// five stage polynomial sine, signed q16 result
`timescale 1ns / 1ps
module rip_sine (
	input logic clk,
	input logic en,
	input logic [rip_pkg::AngW-1:0] angle,
	output logic signed [rip_pkg::SinW-1:0] sine
);
	logic [1:0] q_s1, q_s2, q_s3, q_s4;
	logic [14:0] u_s1, u_s2, u_s3, u_s4;
	logic [14:0] u2_s2, u2_s3;
	logic [15:0] inner_s3;
	logic [16:0] mid_s4;

	logic [14:0] u_c;
	logic [29:0] uu;
	logic [27:0] cu2;
	logic [15:0] inner_c;
	logic [30:0] iu2;
	logic [16:0] mid_c;
	logic [31:0] mu;
	logic [17:0] smag;
	logic [16:0] mag;

	always_comb begin
		u_c = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
		uu = 30'(u_s1) * 30'(u_s1);
		cu2 = 28'(u2_s2) * 28'(rip_pkg::SinC);
		inner_c = 16'(rip_pkg::SinB) - 16'(cu2 >> 14);
		iu2 = 31'(inner_s3) * 31'(u2_s3);
		mid_c = 17'(rip_pkg::SinA) - 17'(iu2 >> 14);
		mu = 32'(mid_s4) * 32'(u_s4);
		smag = 18'(mu >> 14);
		mag = (smag > 18'd65536) ? 17'd65536 : smag[16:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= angle[15:14];
			u_s1 <= u_c;
			q_s2 <= q_s1;
			u_s2 <= u_s1;
			u2_s2 <= 15'(uu >> 14);
			q_s3 <= q_s2;
			u_s3 <= u_s2;
			u2_s3 <= u2_s2;
			inner_s3 <= inner_c;
			q_s4 <= q_s3;
			u_s4 <= u_s3;
			mid_s4 <= mid_c;
			sine <= q_s4[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end
endmodule

// ----- src/rip_mul.sv -----
// two stage 38 x 18 signed multiplier split into two partial products
`timescale 1ns / 1ps
module rip_mul (
	input logic clk,
	input logic en,
	input logic signed [rip_pkg::RsW-1:0] a,
	input logic signed [rip_pkg::SinW-1:0] b,
	output logic signed [rip_pkg::ProdW-1:0] p
);
	logic signed [37:0] pl_c;
	logic signed [36:0] ph_c;
	logic signed [37:0] pl_s1;
	logic signed [36:0] ph_s1;

	always_comb begin
		pl_c = $signed({1'b0, a[18:0]}) * b;
		ph_c = $signed(a[37:19]) * b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl_c;
			ph_s1 <= ph_c;
			p <= ($signed(56'(ph_s1)) <<< 19) + $signed(56'(pl_s1));
		end
	end
endmodule

// ----- src/range_image_to_point_cloud_unit.sv -----
// top level: lidar sample to cartesian point pipeline
// throughput: one word per cycle; the whole pipeline stalls together when the
// output register holds a word that is not taken
// reset: asynchronous, clears the valid pipeline and loads the config registers with their reset values
`timescale 1ns / 1ps
`include "range_image_to_point_cloud_unit_defines.svh"
module range_image_to_point_cloud_unit (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rip_pkg::AddrW-1:0] paddr,
	input logic [rip_pkg::DataW-1:0] pwdata,
	output logic [rip_pkg::DataW-1:0] prdata,
	output logic pready,
	rip_in_if.sink samples,
	rip_out_if.source points
);
	rip_pkg::rip_cfg_t cfg;
	logic en;
	logic [13:1] vld_s;

	logic [rip_pkg::ColW-1:0] col_c;
	logic [rip_pkg::RowW-1:0] row_c;
	logic [26:0] hprod;
	logic [24:0] vprod;
	logic [rip_pkg::AngW-1:0] ha_c, va_c;
	logic [rip_pkg::RangeW-1:0] r_c;

	logic [rip_pkg::AngW-1:0] ha_s1, va_s1;
	logic [rip_pkg::RangeW-1:0] r_s [1:6];
	logic [rip_pkg::IntenW-1:0] inten_s [1:13];

	logic signed [rip_pkg::SinW-1:0] sh_s6, ch_s6, sv_s6, cv_s6, sa, ca;

	logic signed [38:0] rcv_c, rsv_c, rsh_c;
	logic signed [rip_pkg::RsW-1:0] rcv_s7, rsv_s7, rsh_s7, rsv_s8, rsh_s8, rsv_s9, rsh_s9;
	logic signed [rip_pkg::SinW-1:0] ch_s7, sh_s7;
	logic signed [rip_pkg::RsW-1:0] m2a;
	logic signed [rip_pkg::SinW-1:0] m2b;
	logic signed [rip_pkg::ProdW-1:0] m1_s9, m2_s9;

	logic signed [rip_pkg::RsW-1:0] po_c, py_c, pz_c;
	logic signed [rip_pkg::WideW-1:0] px_w, po_w, z_w;
	logic signed [rip_pkg::RsW-1:0] px_s10, py_s10;
	logic signed [rip_pkg::CoordW-1:0] z_s10, z_s11, z_s12;

	logic signed [rip_pkg::ProdW-1:0] cpx_s12, spy_s12, spx_s12, cpy_s12;
	logic signed [rip_pkg::WideW-1:0] xs_c, ys_c;

	logic signed [rip_pkg::CoordW-1:0] x_s13, y_s13, z_s13;

	rip_regs i_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign en = !vld_s[13] || points.ready;
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[12:1], samples.valid};
		end
	end

	// stage 1: angles and range check
	always_comb begin
		col_c = ({1'b0, samples.column} >= 13'(rip_pkg::MaxColumns))
			? rip_pkg::ColW'(rip_pkg::MaxColumns - 1) : samples.column;
		row_c = ({1'b0, samples.row} >= 11'(rip_pkg::MaxRows))
			? rip_pkg::RowW'(rip_pkg::MaxRows - 1) : samples.row;
		hprod = 27'(col_c) * 27'(cfg.h_angle_step);
		vprod = 25'(row_c) * 25'(cfg.v_angle_step);
		ha_c = hprod[15:0] + cfg.h_angle_min - cfg.center_angle;
		va_c = vprod[15:0] + cfg.v_angle_min;
		r_c = (samples.sample_range < cfg.range_lo || samples.sample_range >= cfg.range_hi)
			? cfg.range_hi : samples.sample_range;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ha_s1 <= ha_c;
			va_s1 <= va_c;
			r_s[1] <= r_c;
			inten_s[1] <= samples.sample_intensity;
			for (int i = 2; i <= 6; i++) begin
				r_s[i] <= r_s[i-1];
			end
			for (int i = 2; i <= 13; i++) begin
				inten_s[i] <= inten_s[i-1];
			end
		end
	end

	// stages 2 to 6: sines and cosines
	rip_sine i_sin_h (.clk(clk), .en(en), .angle(ha_s1), .sine(sh_s6));
	rip_sine i_cos_h (.clk(clk), .en(en), .angle(ha_s1 + rip_pkg::QuarterTurn), .sine(ch_s6));
	rip_sine i_sin_v (.clk(clk), .en(en), .angle(va_s1), .sine(sv_s6));
	rip_sine i_cos_v (.clk(clk), .en(en), .angle(va_s1 + rip_pkg::QuarterTurn), .sine(cv_s6));
	rip_sine i_sin_c (.clk(clk), .en(en), .angle(cfg.center_angle), .sine(sa));
	rip_sine i_cos_c (.clk(clk), .en(en),
		.angle(cfg.center_angle + rip_pkg::QuarterTurn), .sine(ca));

	// stage 7: range times vertical terms and horizontal sine
	always_comb begin
		rcv_c = $signed({1'b0, r_s[6]}) * cv_s6;
		rsv_c = $signed({1'b0, r_s[6]}) * sv_s6;
		rsh_c = $signed({1'b0, r_s[6]}) * sh_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rcv_s7 <= rcv_c[37:0];
			rsv_s7 <= rsv_c[37:0];
			rsh_s7 <= rsh_c[37:0];
			ch_s7 <= ch_s6;
			sh_s7 <= sh_s6;
			rsv_s8 <= rsv_s7;
			rsh_s8 <= rsh_s7;
			rsv_s9 <= rsv_s8;
			rsh_s9 <= rsh_s8;
		end
	end

	// stages 8 and 9: second spherical products
	assign m2a = cfg.horizontal_mode ? rsv_s7 : rcv_s7;
	assign m2b = cfg.horizontal_mode ? ch_s7 : sh_s7;

	rip_mul i_mul_px (.clk(clk), .en(en), .a(rcv_s7), .b(ch_s7), .p(m1_s9));
	rip_mul i_mul_po (.clk(clk), .en(en), .a(m2a), .b(m2b), .p(m2_s9));

	// stage 10: rounding and mode select
	always_comb begin
		px_w = rip_pkg::rnd_sh(58'(m1_s9), 16);
		po_w = rip_pkg::rnd_sh(58'(m2_s9), 16);
		po_c = po_w[37:0];
		py_c = cfg.horizontal_mode ? rsh_s9 : po_c;
		pz_c = cfg.horizontal_mode ? po_c : rsv_s9;
		z_w = rip_pkg::rnd_sh(58'(pz_c), 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s10 <= px_w[37:0];
			py_s10 <= py_c;
			z_s10 <= rip_pkg::sat_coord(z_w);
			z_s11 <= z_s10;
			z_s12 <= z_s11;
		end
	end

	// stages 11 and 12: rotation by the center angle
	rip_mul i_mul_cpx (.clk(clk), .en(en), .a(px_s10), .b(ca), .p(cpx_s12));
	rip_mul i_mul_spy (.clk(clk), .en(en), .a(py_s10), .b(sa), .p(spy_s12));
	rip_mul i_mul_spx (.clk(clk), .en(en), .a(px_s10), .b(sa), .p(spx_s12));
	rip_mul i_mul_cpy (.clk(clk), .en(en), .a(py_s10), .b(ca), .p(cpy_s12));

	// stage 13: sum, round, saturate into the output register
	always_comb begin
		xs_c = rip_pkg::rnd_sh(58'(cpx_s12) - 58'(spy_s12), 32);
		ys_c = rip_pkg::rnd_sh(58'(spx_s12) + 58'(cpy_s12), 32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s13 <= rip_pkg::sat_coord(xs_c);
			y_s13 <= rip_pkg::sat_coord(ys_c);
			z_s13 <= z_s12;
		end
	end

	assign points.valid = vld_s[13];
	assign points.point_x = x_s13;
	assign points.point_y = y_s13;
	assign points.point_z = z_s13;
	assign points.point_intensity = inten_s[13];

	`RIP_ASSERT_NXT(a_stall_holds, !en, vld_s == $past(vld_s), "valid pipeline moved in stall")
	`RIP_ASSERT_NXT(a_accept_enters, samples.valid && samples.ready, vld_s[1],
		"accepted word missing from stage one")
	`RIP_ASSERT_IMP(a_x_sat, points.valid,
		(points.point_x >= -21'sd1048575) && (points.point_x <= 21'sd1048575), "x out of range")
	`RIP_ASSERT_IMP(a_z_sat, points.valid,
		(points.point_z >= -21'sd1048575) && (points.point_z <= 21'sd1048575), "z out of range")
endmodule
